[hw/rtl/adi_pkg.sv]
package adi_pkg;

  // one byte waiting in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } char_item_t;

  // one finished conversion
  typedef struct packed {
    logic               valid;
    logic signed [31:0] value;
    logic               error;
  } result_t;

  // handshake state of the output register, seen by the parser
  typedef struct packed {
    logic full;
    logic stall;
  } out_status_t;

endpackage

[hw/rtl/ascii_decimal_to_int32.sv]
// Strict ASCII decimal to signed 32-bit converter.
// Input channel: in_valid / in_stall with char_in, one byte of a NUL-terminated
// string per transaction. Leading whitespace, one optional sign, then digits
// that must run up to the NUL.
// Output channel: out_valid / out_stall with value_out and error. Exactly one
// transaction per string, produced by its NUL byte; error is set (and
// value_out is 0) for an empty string, a stray character or a value outside
// the int32 range.
// Throughput is one byte per clock while in_stall is low. A byte is held in the input
// register, then the parser updates its state and, for a NUL, loads the output
// register, which drives out_valid.
// When the receiver stalls, the result is held in the output register; bytes
// other than NUL keep flowing, and a second NUL waits in the input register,
// asserting in_stall, until the held result is taken.
// Synchronous reset clears both valids and returns the parser to the
// leading-whitespace phase with an empty magnitude.
module ascii_decimal_to_int32 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value_out,
  output logic               error
);
  import adi_pkg::*;

  char_item_t  item;
  result_t     result;
  out_status_t out_status;
  logic        advance;

  adi_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .char_in  (char_in),
    .advance  (advance),
    .in_stall (in_stall),
    .item     (item)
  );

  adi_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .out_status (out_status),
    .advance    (advance),
    .result     (result)
  );

  adi_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .result     (result),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_valid  (out_valid),
    .value_out  (value_out),
    .error      (error)
  );

  // input back-pressure only comes from a held result
  assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid && out_stall)
    else $error("in_stall without a held result");

  // an error result always carries zero
  assert property (@(posedge clk) disable iff (rst) out_valid && error |-> value_out == 32'sd0)
    else $error("error result with nonzero value");

  // reset empties the output register
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid after reset");

endmodule

[hw/rtl/adi_in_stage.sv]
module adi_in_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [7:0]         char_in,
  input  logic               advance,
  output logic               in_stall,
  output adi_pkg::char_item_t item
);
  import adi_pkg::*;

  logic       held_valid;
  logic       held_valid_next;
  logic [7:0] held_char;
  logic       take;

  // stall only while the held byte cannot move on
  assign in_stall = held_valid && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    if (take) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end else begin
      held_valid_next = held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_char <= char_in;
    end
  end

  assign item.valid = held_valid;
  assign item.ch    = held_char;

endmodule

[hw/rtl/adi_parse.sv]
module adi_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  adi_pkg::char_item_t  item,
  input  adi_pkg::out_status_t out_status,
  output logic                 advance,
  output adi_pkg::result_t     result
);
  import adi_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD   = 3'b001,
    PH_SIGN   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_t;

  localparam logic [7:0]  CH_NUL    = 8'h00;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_PLUS   = 8'h2B;
  localparam logic [7:0]  CH_MINUS  = 8'h2D;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_TAB    = 8'h09;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [31:0] LIMIT_MAG = 32'h8000_0000;

  phase_t      phase;
  phase_t      phase_next;
  logic        negative;
  logic        negative_next;
  logic [31:0] magnitude;
  logic [31:0] magnitude_next;
  logic        overflowed;
  logic        overflowed_next;
  logic        bad_char;
  logic        bad_char_next;

  logic        is_nul;
  logic        is_digit;
  logic        is_blank;
  logic        is_sign;
  logic        in_lead;
  logic        in_digits;
  logic [3:0]  digit;
  logic [34:0] prod;
  logic        err;

  assign is_nul   = (item.ch == CH_NUL);
  assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
  assign is_blank = (item.ch == CH_SPACE) || ((item.ch >= CH_TAB) && (item.ch <= CH_CR));
  assign is_sign  = (item.ch == CH_PLUS) || (item.ch == CH_MINUS);
  assign digit    = 4'(item.ch - CH_ZERO);

  // magnitude * 10 + digit as two shifts and two adds
  assign prod = {magnitude, 3'b000} + {2'b00, magnitude, 1'b0} + {31'd0, digit};

  always_comb begin
    unique case (phase)
      PH_LEAD: begin
        in_lead   = 1'b1;
        in_digits = 1'b0;
      end
      PH_SIGN: begin
        in_lead   = 1'b0;
        in_digits = 1'b0;
      end
      default: begin
        in_lead   = 1'b0;
        in_digits = 1'b1;
      end
    endcase
  end

  // a nul waits only when the output register is still held
  assign advance = item.valid && (!is_nul || !out_status.full || !out_status.stall);

  // a saturated magnitude of 2^31 is only legal as a negative value
  assign err = bad_char || !in_digits || overflowed || (!negative && magnitude[31]);

  assign result.valid = advance && is_nul;
  assign result.error = err;
  assign result.value = err ? 32'sd0 : (negative ? $signed(32'd0 - magnitude)
                                                  : $signed(magnitude));

  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    magnitude_next  = magnitude;
    overflowed_next = overflowed;
    bad_char_next   = bad_char;
    if (advance) begin
      priority if (is_nul) begin
        phase_next      = PH_LEAD;
        negative_next   = 1'b0;
        magnitude_next  = 32'd0;
        overflowed_next = 1'b0;
        bad_char_next   = 1'b0;
      end else if (bad_char) begin
        // rest of the string is ignored
      end else if (is_digit) begin
        phase_next = PH_DIGITS;
        if (prod > {3'b000, LIMIT_MAG}) begin
          overflowed_next = 1'b1;
          magnitude_next  = LIMIT_MAG;
        end else begin
          magnitude_next = prod[31:0];
        end
      end else if (in_lead && is_blank) begin
        // skip leading whitespace
      end else if (in_lead && is_sign) begin
        negative_next = (item.ch == CH_MINUS);
        phase_next    = PH_SIGN;
      end else begin
        bad_char_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_LEAD;
      negative   <= 1'b0;
      magnitude  <= 32'd0;
      overflowed <= 1'b0;
      bad_char   <= 1'b0;
    end else begin
      phase      <= phase_next;
      negative   <= negative_next;
      magnitude  <= magnitude_next;
      overflowed <= overflowed_next;
      bad_char   <= bad_char_next;
    end
  end

endmodule

[hw/rtl/adi_out_stage.sv]
module adi_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  adi_pkg::result_t      result,
  input  logic                  out_stall,
  output adi_pkg::out_status_t  out_status,
  output logic                  out_valid,
  output logic signed [31:0]    value_out,
  output logic                  error
);
  import adi_pkg::*;

  logic out_valid_next;

  // the parser only hands over a result when this register is free to take it
  always_comb begin
    if (result.valid) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      value_out <= result.value;
      error     <= result.error;
    end
  end

  assign out_status.full  = out_valid;
  assign out_status.stall = out_stall;

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_VT    = 8'h0b;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HIGH  = 8'hff;

  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;

  localparam int unsigned ITEM_TARGET    = 1900;
  localparam int unsigned QUIET_TAIL     = 200;
  localparam int unsigned HOLD_CYCLES    = 150;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES    = 20;

  typedef enum logic [1:0] {PH_LEAD, PH_SIGN, PH_DIGITS} parse_phase_e;
  typedef enum logic [1:0] {STIM_CHAR, STIM_HOLD, STIM_DRAIN, STIM_QUIET} stim_kind_e;

  typedef struct {
    stim_kind_e kind;
    logic [7:0] ch;
  } stim_t;

  typedef struct {
    logic signed [31:0] value;
    logic               error;
  } conv_t;

  typedef logic [7:0] byte_q_t[$];

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_in = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value_out;
  logic               error;

  ascii_decimal_to_int32 u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_in   (char_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .error     (error)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // parser state mirrored in the testbench
  parse_phase_e parse_phase = PH_LEAD;
  logic         neg_seen = 1'b0;
  logic [31:0]  mag = '0;
  logic         ovf_seen = 1'b0;
  logic         bad_seen = 1'b0;

  stim_t       pending_stim[$];
  conv_t       expected_conv[$];
  bit          char_taken = 0;
  bit          hold_request = 0;
  bit          quiet_tail = 0;
  bit          send_idle_mode = 1;
  bit          recv_idle_mode = 1;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned chars_queued = 0;
  int unsigned strings_queued = 0;
  int unsigned chars_taken = 0;
  int unsigned results_checked = 0;
  int unsigned error_results = 0;
  int unsigned negative_results = 0;
  int unsigned in_stall_run = 0;
  int unsigned max_in_stall_run = 0;

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
           c == CH_CR;
  endfunction

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_VT;
      3: return CH_FF;
      4: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  // advance the mirrored parser by one accepted byte, queue the conversion at NUL
  task automatic parse_char(input logic [7:0] c);
    conv_t       r;
    logic [35:0] acc;
    if (c == CH_NUL) begin
      r.error = bad_seen || parse_phase != PH_DIGITS || ovf_seen || (!neg_seen && mag[31]);
      r.value = r.error ? 32'sd0 : (neg_seen ? -$signed(mag) : $signed(mag));
      expected_conv.push_back(r);
      parse_phase = PH_LEAD;
      neg_seen = 1'b0;
      mag = '0;
      ovf_seen = 1'b0;
      bad_seen = 1'b0;
    end else if (!bad_seen) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        acc = {4'd0, mag} * 36'd10 + {28'd0, c - CH_ZERO};
        if (acc > MAG_LIMIT) begin
          ovf_seen = 1'b1;
          acc = MAG_LIMIT;
        end
        mag = acc[31:0];
        parse_phase = PH_DIGITS;
      end else if (parse_phase == PH_LEAD && is_blank(c)) begin
      end else if (parse_phase == PH_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
        neg_seen = (c == CH_MINUS);
        parse_phase = PH_SIGN;
      end else begin
        bad_seen = 1'b1;
      end
    end
  endtask

  task automatic queue_string(input byte_q_t b);
    foreach (b[i]) pending_stim.push_back('{kind: STIM_CHAR, ch: b[i]});
    pending_stim.push_back('{kind: STIM_CHAR, ch: CH_NUL});
    chars_queued += b.size() + 1;
    strings_queued++;
  endtask

  task automatic queue_text(input string s);
    byte_q_t b;
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    queue_string(b);
  endtask

  // mostly well-formed numbers, some corrupted, some plain noise
  task automatic queue_random_string();
    byte_q_t     b;
    int unsigned shape;
    int unsigned pos;
    longint      near_val;
    string       s;
    shape = $urandom_range(0, 9);
    if (shape == 9) begin
      repeat ($urandom_range(0, 6)) b.push_back(8'($urandom_range(1, 255)));
    end else begin
      repeat ($urandom_range(0, 2)) b.push_back(random_blank());
      case ($urandom_range(0, 2))
        1: b.push_back(CH_PLUS);
        2: b.push_back(CH_MINUS);
        default: ;
      endcase
      if ($urandom_range(0, 4) == 0) begin
        // values around the int32 limits
        near_val = 64'd2147483645 + longint'($urandom_range(0, 6));
        s = $sformatf("%0d", near_val);
        for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
      end else begin
        repeat ($urandom_range(1, 11)) b.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      end
      pos = $urandom_range(0, b.size() - 1);
      if (shape == 7) begin
        b.insert(pos, 8'($urandom_range(1, 255)));
      end else if (shape == 8) begin
        b.insert(pos, $urandom_range(0, 1) ? CH_MINUS : random_blank());
      end
    end
    queue_string(b);
  endtask

  initial begin : stimulus
    bit hold_done;
    bit drain_done;
    bit quiet_done;
    hold_done = 0;
    drain_done = 0;
    quiet_done = 0;

    queue_text("");
    queue_string('{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
    queue_text("+");
    queue_text("-");
    queue_text("0");
    queue_text("-0");
    queue_text("2147483647");
    queue_text("-2147483648");
    queue_text("2147483648");
    queue_text("-2147483649");
    queue_text("4294967306");
    queue_string('{CH_SPACE, CH_TAB, CH_PLUS, 8'h34, 8'h32});
    queue_text("--5");
    queue_text("+ 5");
    queue_text("12 ");
    queue_text("1a2");
    queue_string('{CH_HIGH, 8'h31});
    pending_stim.push_back('{kind: STIM_DRAIN, ch: CH_NUL});

    while (chars_queued < ITEM_TARGET) begin
      if (!hold_done && chars_queued >= ITEM_TARGET / 3) begin
        // receiver holds off while short strings pile up behind it
        pending_stim.push_back('{kind: STIM_HOLD, ch: CH_NUL});
        repeat (20) queue_text($sformatf("%0d", $urandom_range(0, 99)));
        hold_done = 1;
      end
      if (!drain_done && chars_queued >= 2 * ITEM_TARGET / 3) begin
        pending_stim.push_back('{kind: STIM_DRAIN, ch: CH_NUL});
        drain_done = 1;
      end
      if (!quiet_done && chars_queued >= ITEM_TARGET - QUIET_TAIL) begin
        pending_stim.push_back('{kind: STIM_QUIET, ch: CH_NUL});
        quiet_done = 1;
      end
      queue_random_string();
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (pending_stim.size() == 0 && !in_valid);
    wait (expected_conv.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d bytes in %0d strings, %0d conversions checked (%0d errors, %0d negative)",
             chars_taken, strings_queued, results_checked, error_results, negative_results);
    $display("longest input backpressure %0d cycles, receiver hold-off %0d cycles",
             max_in_stall_run, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    wait (!rst);
    while (idle_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // sender: offers one byte at a time, pops control markers between bytes
  always @(negedge clk) begin : drive_chars
    logic       nv;
    logic [7:0] nc;
    bit         done;
    nv = in_valid;
    nc = char_in;
    if (cycle_count % 64 == 0) send_idle_mode = $urandom_range(0, 2) != 0;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (char_taken) begin
        char_taken = 0;
        nv = 1'b0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (!quiet_tail && send_idle_mode && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 2);
        end else begin
          done = 0;
          while (!done && pending_stim.size() > 0) begin
            case (pending_stim[0].kind)
              STIM_CHAR: begin
                nc = pending_stim[0].ch;
                nv = 1'b1;
                void'(pending_stim.pop_front());
                done = 1;
              end
              STIM_HOLD: begin
                hold_request = 1;
                void'(pending_stim.pop_front());
              end
              STIM_QUIET: begin
                quiet_tail = 1;
                void'(pending_stim.pop_front());
              end
              default: begin
                // sender waits here until every conversion has come out
                if (expected_conv.size() == 0) void'(pending_stim.pop_front());
                else done = 1;
              end
            endcase
          end
        end
      end
    end
    in_valid <= nv;
    char_in <= nc;
  end

  // receiver: short random stalls plus one long hold-off
  always @(negedge clk) begin : drive_stall
    logic ns;
    if (cycle_count % 64 == 32) recv_idle_mode = $urandom_range(0, 2) != 0;
    if (rst) begin
      ns = 1'b0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left = HOLD_CYCLES - 1;
      ns = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      ns = 1'b1;
    end else if (!quiet_tail && recv_idle_mode && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      ns = 1'b1;
    end else begin
      ns = 1'b0;
    end
    out_stall <= ns;
  end

  always @(posedge clk) begin : watch_ports
    conv_t want;
    cycle_count++;
    if (!rst) begin
      idle_cycles++;
      // check the output first so a NUL taken at this edge cannot mask a stray result
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (expected_conv.size() == 0) begin
          $error("unexpected transaction: value_out %0d error %0b", value_out, error);
          fail_count++;
        end else begin
          want = expected_conv.pop_front();
          results_checked++;
          if (want.error) error_results++;
          if (want.value < 0) negative_results++;
          if (value_out !== want.value) begin
            $error("value_out: expected %0d, got %0d", want.value, value_out);
            fail_count++;
          end
          if (error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, error);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        parse_char(char_in);
        char_taken = 1;
        chars_taken++;
        idle_cycles = 0;
      end
      if (in_valid && in_stall) begin
        in_stall_run++;
        if (in_stall_run > max_in_stall_run) max_in_stall_run = in_stall_run;
      end else begin
        in_stall_run = 0;
      end
    end
  end

endmodule

[filelist.f]
hw/rtl/adi_pkg.sv
hw/rtl/adi_in_stage.sv
hw/rtl/adi_parse.sv
hw/rtl/adi_out_stage.sv
hw/rtl/ascii_decimal_to_int32.sv
tb/tb.sv
